>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/ghsa_pkg.sv
// Shared constants and codes of the generational handle slot allocator.
package ghsa_pkg;

   localparam int SLOTS  = 64;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int GEN_W  = 32;
   localparam int REF_W  = 32;
   localparam int HIDX_W = 8;
   localparam int OIDX_W = 6;
   localparam int LIVE_W = 7;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 80;

   // Response field offsets.
   localparam int RSP_IDX_LSB  = 2;
   localparam int RSP_GEN_LSB  = 8;
   localparam int RSP_REF_LSB  = 40;
   localparam int RSP_LIVE_LSB = 72;

   typedef enum logic [2:0] {
      FUNC_CREATE   = 3'd0,
      FUNC_REGISTER = 3'd1,
      FUNC_RELEASE  = 3'd2,
      FUNC_LOOKUP   = 3'd3,
      FUNC_FIND     = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EXISTS   = 2'd1,
      ST_INVALID  = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

endpackage

>>> rtl/generational_handle_slot_allocator_core.sv
// Generational handle slot table with a LIFO free stack and a sequential reference scan.
//
//   channel   direction   transfer contents
//   req_*     in          func, slot_index, slot_generation, object_ref
//   rsp_*     out         status, handle_index, handle_generation, ref_out, live_count
//
// One request at a time; req_tready is high only while the sequencer is idle.
// Register and find scan the slot table one slot per cycle through the shared read port,
// and register then allocates when no alive slot holds the reference. Reset clears
// alive, generation-written and stack-written bits.
// A stalled response holds the sequencer in its final state until the transfer.
module generational_handle_slot_allocator_core
   import ghsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] func, [10:3] slot_index, [42:11] slot_generation, [74:43] object_ref
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] status, [7:2] handle_index, [39:8] handle_generation,
   // [71:40] ref_out, [78:72] live_count
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_TAKE,
      S_TAKE_IDX,
      S_TAKE_GEN,
      S_HCHK,
      S_EMIT
   } state_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] idx;
      logic [GEN_W-1:0]  gen;
      logic [REF_W-1:0]  ref_val;
   } result_type;

   state_type               state_ff, state_in;
   logic [2:0]              func_ff, func_in;
   logic [HIDX_W-1:0]       hidx_ff, hidx_in;
   logic [GEN_W-1:0]        hgen_ff, hgen_in;
   logic [REF_W-1:0]        oref_ff, oref_in;
   logic [SLOT_W-1:0]       idx_ff, idx_in;
   result_type              res_ff, res_in;
   logic [SLOTS-1:0]        alive_ff, alive_in;
   logic [SLOTS-1:0]        gen_vld_ff, gen_vld_in;
   logic [SLOTS-1:0]        stk_vld_ff, stk_vld_in;
   logic [CNT_W-1:0]        free_depth_ff, free_depth_in;
   logic [CNT_W-1:0]        alive_total_ff, alive_total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // Slot and stack memories
   logic [GEN_W-1:0]        gen_mem [SLOTS];
   logic [REF_W-1:0]        ref_mem [SLOTS];
   logic [SLOT_W-1:0]       stk_mem [SLOTS];

   logic [SLOT_W-1:0]       mem_raddr;
   logic [GEN_W-1:0]        gen_rd_ff;
   logic                    gen_vld_rd_ff;
   logic [REF_W-1:0]        ref_rd_ff;
   logic                    gen_we;
   logic [SLOT_W-1:0]       gen_waddr;
   logic [GEN_W-1:0]        gen_wdata;
   logic                    ref_we;
   logic [SLOT_W-1:0]       ref_waddr;

   logic [SLOT_W-1:0]       stk_raddr;
   logic [SLOT_W-1:0]       stk_rd_ff;
   logic                    stk_vld_rd_ff;
   logic                    stk_we;
   logic [SLOT_W-1:0]       stk_waddr;
   logic [SLOT_W-1:0]       stk_wdata;

   logic [GEN_W-1:0]        gen_eff;
   logic                    scan_hit;
   logic                    handle_hit;
   logic [SLOT_W-1:0]       popped_idx;
   logic [SLOT_W-1:0]       hidx_slot;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Never-written generation entries read as zero.
   assign gen_eff    = gen_vld_rd_ff ? gen_rd_ff : '0;
   assign hidx_slot  = hidx_ff[SLOT_W-1:0];
   assign scan_hit   = alive_ff[idx_ff] && (ref_rd_ff == oref_ff);
   assign handle_hit = alive_ff[hidx_slot] && (gen_eff == hgen_ff);
   // Never-written stack entry k holds SLOTS-1-k; the popped entry is at free_depth_ff.
   assign popped_idx = stk_vld_rd_ff ? stk_rd_ff
                                     : (SLOT_W'(SLOTS - 1) - free_depth_ff[SLOT_W-1:0]);

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      hidx_in        = hidx_ff;
      hgen_in        = hgen_ff;
      oref_in        = oref_ff;
      idx_in         = idx_ff;
      res_in         = res_ff;
      alive_in       = alive_ff;
      gen_vld_in     = gen_vld_ff;
      stk_vld_in     = stk_vld_ff;
      free_depth_in  = free_depth_ff;
      alive_total_in = alive_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      mem_raddr      = idx_ff + SLOT_W'(1);
      stk_raddr      = SLOT_W'(free_depth_ff - CNT_W'(1));
      gen_we         = 1'b0;
      gen_waddr      = hidx_slot;
      gen_wdata      = gen_eff + GEN_W'(1);
      ref_we         = 1'b0;
      ref_waddr      = popped_idx;
      stk_we         = 1'b0;
      stk_waddr      = free_depth_ff[SLOT_W-1:0];
      stk_wdata      = hidx_slot;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tdata[2:0];
               hidx_in  = req_tdata[10:3];
               hgen_in  = req_tdata[42:11];
               oref_in  = req_tdata[74:43];
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_in   = '{status: ST_INVALID, idx: '0, gen: '0, ref_val: '0};
            state_in = S_EMIT;
            case (func_ff) inside
               FUNC_CREATE: begin
                  state_in = S_TAKE;
               end
               FUNC_REGISTER, FUNC_FIND: begin
                  if (oref_ff != '0) begin
                     mem_raddr = '0;
                     idx_in    = '0;
                     state_in  = S_SCAN;
                  end
               end
               FUNC_RELEASE, FUNC_LOOKUP: begin
                  mem_raddr = hidx_slot;
                  if (hidx_ff < HIDX_W'(SLOTS)) begin
                     state_in = S_HCHK;
                  end
               end
               default: begin
                  state_in = S_EMIT;
               end
            endcase
         end
         S_SCAN: begin
            // Data for slot idx_ff is present; next slot is being read.
            if (scan_hit) begin
               res_in.status = (func_ff == FUNC_REGISTER) ? ST_EXISTS : ST_OK;
               res_in.idx    = idx_ff;
               res_in.gen    = gen_eff;
               state_in      = S_EMIT;
            end else if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = (func_ff == FUNC_REGISTER) ? S_TAKE : S_EMIT;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         S_TAKE: begin
            if (free_depth_ff == '0) begin
               res_in.status = ST_FULL;
               state_in      = S_EMIT;
            end else begin
               free_depth_in = free_depth_ff - CNT_W'(1);
               state_in      = S_TAKE_IDX;
            end
         end
         S_TAKE_IDX: begin
            mem_raddr            = popped_idx;
            idx_in               = popped_idx;
            ref_we               = 1'b1;
            alive_in[popped_idx] = 1'b1;
            alive_total_in       = alive_total_ff + CNT_W'(1);
            state_in             = S_TAKE_GEN;
         end
         S_TAKE_GEN: begin
            res_in.status = ST_OK;
            res_in.idx    = idx_ff;
            res_in.gen    = gen_eff;
            state_in      = S_EMIT;
         end
         S_HCHK: begin
            state_in = S_EMIT;
            if (func_ff == FUNC_LOOKUP) begin
               if (handle_hit) begin
                  res_in = '{status: ST_OK, idx: hidx_slot, gen: hgen_ff, ref_val: ref_rd_ff};
               end
            end else if (handle_hit && (free_depth_ff < CNT_W'(SLOTS))) begin
               alive_in[hidx_slot]   = 1'b0;
               gen_we                = 1'b1;
               gen_vld_in[hidx_slot] = 1'b1;
               stk_we                = 1'b1;
               stk_vld_in[free_depth_ff[SLOT_W-1:0]] = 1'b1;
               free_depth_in         = free_depth_ff + CNT_W'(1);
               alive_total_in        = alive_total_ff - CNT_W'(1);
               res_in = '{status: ST_OK, idx: hidx_slot, gen: hgen_ff, ref_val: '0};
            end
         end
         S_EMIT: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, LIVE_W'(alive_total_ff), res_ff.ref_val, res_ff.gen,
                               OIDX_W'(res_ff.idx), res_ff.status};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      hidx_ff     <= hidx_in;
      hgen_ff     <= hgen_in;
      oref_ff     <= oref_in;
      idx_ff      <= idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         alive_ff       <= '0;
         gen_vld_ff     <= '0;
         stk_vld_ff     <= '0;
         free_depth_ff  <= CNT_W'(SLOTS);
         alive_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         alive_ff       <= alive_in;
         gen_vld_ff     <= gen_vld_in;
         stk_vld_ff     <= stk_vld_in;
         free_depth_ff  <= free_depth_in;
         alive_total_ff <= alive_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Generation and reference memories share one read address.
   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[gen_waddr] <= gen_wdata;
      end
      gen_rd_ff     <= gen_mem[mem_raddr];
      gen_vld_rd_ff <= gen_vld_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[ref_waddr] <= oref_ff;
      end
      ref_rd_ff <= ref_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff     <= stk_mem[stk_raddr];
      stk_vld_rd_ff <= stk_vld_ff[stk_raddr];
   end

endmodule

>>> rtl/ghsa_checker.sv
// Port-level assertions for the slot allocator core, bound into every core instance.
`include "assert_macros.svh"

module ghsa_checker
   import ghsa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic err_status;
   logic req_xfer;

   assign err_status = (rsp_tdata[1:0] == ST_INVALID) || (rsp_tdata[1:0] == ST_FULL);
   assign req_xfer   = req_tvalid && req_tready;

   `ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, reset, !rsp_tvalid)
   `ASSERT_NEXT(a_rsp_holds, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_SAME(a_err_zero_fields, rsp_tvalid && err_status,
                rsp_tdata[RSP_LIVE_LSB-1:RSP_IDX_LSB] == '0)
   `ASSERT_SAME(a_live_bounded, rsp_tvalid,
                rsp_tdata[RSP_DATA_W-2:RSP_LIVE_LSB] <= LIVE_W'(SLOTS))
   `ASSERT_NEXT(a_busy_after_req, req_xfer, !req_tready)

endmodule

bind generational_handle_slot_allocator_core ghsa_checker u_ghsa_checker (.*);

>>> tb/tb_generational_handle_slot_allocator_core.sv
// Testbench for the slot allocator: directed and random traffic against a slot table predictor.
`timescale 1ns / 100ps

module tb_generational_handle_slot_allocator_core;
   import ghsa_pkg::*;

   localparam logic [2:0]  FUNC_FIRST_UNUSED = 3'd5;
   localparam logic [2:0]  FUNC_LAST_CODE    = 3'd7;
   localparam int          RANDOM_ITEMS      = 1225;
   localparam int          MAX_GAP           = 18;
   localparam int          LONG_HOLD_CYCLES  = 400;
   localparam int          HOLD_AFTER        = 300;
   localparam int          SETTLE_CYCLES     = 3 * SLOTS;
   localparam int unsigned TIMEOUT_CYCLES    = 1_000_000;
   // Operation mix per random phase: cumulative percent for create, register,
   // release, lookup, find; the remainder uses unassigned codes.
   localparam int MIX [3][5] = '{'{50, 75, 80, 88, 96},   // filling
                                 '{18, 38, 60, 78, 96},   // balanced
                                 '{ 4,  8, 68, 82, 96}};  // draining

   typedef struct packed {
      logic [REF_W-1:0]  obj_ref;
      logic [GEN_W-1:0]  gen;
      logic [HIDX_W-1:0] idx;
      logic [2:0]        func;
   } slot_request_type;

   typedef struct packed {
      logic [LIVE_W-1:0] live_count;
      logic [REF_W-1:0]  ref_out;
      logic [GEN_W-1:0]  handle_gen;
      logic [OIDX_W-1:0] handle_idx;
      status_type        status;
   } slot_response_type;

   class slot_table_scoreboard;
      bit               slot_alive [SLOTS];
      logic [GEN_W-1:0] slot_gen   [SLOTS];
      logic [REF_W-1:0] slot_obj   [SLOTS];
      int               free_slots [SLOTS];
      int               free_depth;
      int               live;
      slot_response_type expected_responses [$];
      int               fail_count;
      int               checked_count;

      function new();
         for (int k = 0; k < SLOTS; k++) begin
            slot_alive[k] = 1'b0;
            slot_gen[k]   = '0;
            slot_obj[k]   = '0;
            free_slots[k] = SLOTS - 1 - k;
         end
         free_depth    = SLOTS;
         live          = 0;
         fail_count    = 0;
         checked_count = 0;
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      function bit handle_valid(logic [HIDX_W-1:0] idx, logic [GEN_W-1:0] g);
         return idx < SLOTS && slot_alive[idx] && slot_gen[idx] == g;
      endfunction

      // Lowest alive slot holding obj, or -1.
      function int find_live_slot(logic [REF_W-1:0] obj);
         for (int k = 0; k < SLOTS; k++)
            if (slot_alive[k] && slot_obj[k] == obj) return k;
         return -1;
      endfunction

      // Pop the free stack and bring the slot alive; -1 when the table is full.
      function int claim_slot(logic [REF_W-1:0] obj);
         int slot;
         if (free_depth == 0) return -1;
         free_depth--;
         slot = free_slots[free_depth];
         slot_alive[slot] = 1'b1;
         slot_obj[slot]   = obj;
         live++;
         return slot;
      endfunction

      function void note_request(slot_request_type rq);
         slot_response_type rs;
         int slot;
         rs = '0;
         rs.status = ST_INVALID;
         case (rq.func) inside
            FUNC_CREATE, FUNC_REGISTER: begin
               slot = -1;
               if (rq.func == FUNC_REGISTER && rq.obj_ref != '0)
                  slot = find_live_slot(rq.obj_ref);
               if (slot >= 0) begin
                  rs.status     = ST_EXISTS;
                  rs.handle_idx = OIDX_W'(slot);
                  rs.handle_gen = slot_gen[slot];
               end else if (rq.func == FUNC_CREATE || rq.obj_ref != '0) begin
                  slot = claim_slot(rq.obj_ref);
                  if (slot < 0) begin
                     rs.status = ST_FULL;
                  end else begin
                     rs.status     = ST_OK;
                     rs.handle_idx = OIDX_W'(slot);
                     rs.handle_gen = slot_gen[slot];
                  end
               end
            end
            FUNC_RELEASE: begin
               if (handle_valid(rq.idx, rq.gen) && free_depth < SLOTS) begin
                  slot_alive[rq.idx] = 1'b0;
                  slot_obj[rq.idx]   = '0;
                  slot_gen[rq.idx]   = slot_gen[rq.idx] + 1'b1;
                  free_slots[free_depth] = int'(rq.idx);
                  free_depth++;
                  if (live > 0) live--;
                  rs.status     = ST_OK;
                  rs.handle_idx = rq.idx[OIDX_W-1:0];
                  rs.handle_gen = rq.gen;
               end
            end
            FUNC_LOOKUP: begin
               if (handle_valid(rq.idx, rq.gen)) begin
                  rs.status     = ST_OK;
                  rs.handle_idx = rq.idx[OIDX_W-1:0];
                  rs.handle_gen = rq.gen;
                  rs.ref_out    = slot_obj[rq.idx];
               end
            end
            FUNC_FIND: begin
               slot = (rq.obj_ref == '0) ? -1 : find_live_slot(rq.obj_ref);
               if (slot >= 0) begin
                  rs.status     = ST_OK;
                  rs.handle_idx = OIDX_W'(slot);
                  rs.handle_gen = slot_gen[slot];
               end
            end
            default: ;
         endcase
         rs.live_count = live[LIVE_W-1:0];
         expected_responses.push_back(rs);
      endfunction

      task report(string field, logic [31:0] got, logic [31:0] want);
         fail_count++;
         $display("%0t: response %0d: %s is %0h, expected %0h",
                  $time, checked_count, field, got, want);
      endtask

      task check_response(logic [RSP_DATA_W-1:0] word);
         slot_response_type got, want;
         checked_count++;
         got = word[$bits(slot_response_type)-1:0];
         if (expected_responses.size() == 0) begin
            report("transfer with nothing pending, low word", word[31:0], '0);
            return;
         end
         want = expected_responses.pop_front();
         if (got.status != want.status)         report("status", 32'(got.status),
                                                       32'(want.status));
         if (got.handle_idx != want.handle_idx) report("handle_index", 32'(got.handle_idx),
                                                       32'(want.handle_idx));
         if (got.handle_gen != want.handle_gen) report("handle_generation", got.handle_gen,
                                                       want.handle_gen);
         if (got.ref_out != want.ref_out)       report("ref_out", got.ref_out, want.ref_out);
         if (got.live_count != want.live_count) report("live_count", 32'(got.live_count),
                                                       32'(want.live_count));
      endtask
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   bit                    no_idle    = 1'b0;

   slot_table_scoreboard sb = new();

   generational_handle_slot_allocator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("** generational_handle_slot_allocator_core: FAILED **");
      $finish;
   end

   function automatic int idle_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic slot_request_type make_op(logic [2:0] func, logic [HIDX_W-1:0] idx,
                                                logic [GEN_W-1:0] g, logic [REF_W-1:0] obj);
      slot_request_type rq;
      rq.func    = func;
      rq.idx     = idx;
      rq.gen     = g;
      rq.obj_ref = obj;
      return rq;
   endfunction

   function automatic int pick_live_slot();
      int live_list [$];
      for (int k = 0; k < SLOTS; k++)
         if (sb.slot_alive[k]) live_list.push_back(k);
      if (live_list.size() == 0) return -1;
      return live_list[$urandom_range(0, live_list.size() - 1)];
   endfunction

   // Favor a small pool so that register and find hit existing entries.
   function automatic logic [REF_W-1:0] pick_object_ref();
      int p, slot;
      p = $urandom_range(0, 99);
      if (p < 40) return $urandom_range(1, 12);
      if (p < 55) begin
         slot = pick_live_slot();
         return (slot < 0) ? 32'd1 : sb.slot_obj[slot];
      end
      if (p < 62) return '0;
      if (p < 68) return '1;
      return $urandom;
   endfunction

   task automatic send_request(slot_request_type rq);
      int gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - $bits(slot_request_type)){1'b0}}, rq};
      do @(posedge clock); while (!req_tready);
      sb.note_request(rq);
   endtask

   // Drop valid and hold until every pending response has arrived.
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin : response_sink
      int gap;
      bit held;
      held = 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = idle_gap();
         if (!held && sb.checked_count >= HOLD_AFTER) begin
            gap  = LONG_HOLD_CYCLES;
            held = 1'b1;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata);
      end
   end

   initial begin : stimulus
      slot_request_type plan [$];
      slot_request_type rq;
      int sent, phase, mode, count, r, slot, p;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table, zero references, duplicates, stale, dead and out-of-range
      // handles, LIFO reuse, unassigned codes.
      plan.push_back(make_op(FUNC_LOOKUP,   8'd0,   '0, '0));
      plan.push_back(make_op(FUNC_FIND,     8'd0,   '0, 32'd1));
      plan.push_back(make_op(FUNC_REGISTER, 8'd0,   '0, '0));
      plan.push_back(make_op(FUNC_FIND,     8'd0,   '0, '0));
      plan.push_back(make_op(FUNC_CREATE,   8'd0,   '0, '0));
      plan.push_back(make_op(FUNC_CREATE,   '1,     '1, '1));
      plan.push_back(make_op(FUNC_REGISTER, 8'd0,   '0, '1));
      plan.push_back(make_op(FUNC_REGISTER, 8'd0,   '0, 32'h1234_5678));
      plan.push_back(make_op(FUNC_CREATE,   8'd0,   '0, 32'h1234_5678));
      plan.push_back(make_op(FUNC_FIND,     8'd0,   '0, 32'h1234_5678));
      plan.push_back(make_op(FUNC_LOOKUP,   8'd0,   '0, '0));
      plan.push_back(make_op(FUNC_LOOKUP,   8'd1,   '0, '1));
      plan.push_back(make_op(FUNC_LOOKUP,   '1,     '1, '0));
      plan.push_back(make_op(FUNC_LOOKUP,   HIDX_W'(SLOTS), '0, '0));
      plan.push_back(make_op(FUNC_RELEASE,  8'd1,   32'd1, '0));
      plan.push_back(make_op(FUNC_RELEASE,  8'd1,   '0, '0));
      plan.push_back(make_op(FUNC_RELEASE,  8'd1,   '0, '0));
      plan.push_back(make_op(FUNC_LOOKUP,   8'd1,   '0, '0));
      plan.push_back(make_op(FUNC_CREATE,   8'd0,   '0, 32'h0000_abcd));
      plan.push_back(make_op(FUNC_LOOKUP,   8'd1,   32'd1, '0));
      plan.push_back(make_op(FUNC_FIRST_UNUSED, '1, '1, '1));
      plan.push_back(make_op(FUNC_FIRST_UNUSED + 3'd1, '0, '0, '0));
      plan.push_back(make_op(FUNC_LAST_CODE, '1,    '1, '1));
      plan.push_back(make_op(FUNC_FIND,     8'd0,   '0, '1));
      plan.push_back(make_op(FUNC_REGISTER, 8'd0,   '0, 32'h1234_5678));
      foreach (plan[k]) send_request(plan[k]);
      drain_responses();

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         mode    = phase % 3;
         no_idle = (phase % 4 == 2);
         count   = $urandom_range(120, 180);
         for (int n = 0; n < count && sent < RANDOM_ITEMS; n++) begin
            rq.obj_ref = $urandom;
            rq.gen     = $urandom;
            rq.idx     = HIDX_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < MIX[mode][0])      rq.func = FUNC_CREATE;
            else if (r < MIX[mode][1]) rq.func = FUNC_REGISTER;
            else if (r < MIX[mode][2]) rq.func = FUNC_RELEASE;
            else if (r < MIX[mode][3]) rq.func = FUNC_LOOKUP;
            else if (r < MIX[mode][4]) rq.func = FUNC_FIND;
            else rq.func = 3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_CODE));
            if (rq.func == FUNC_CREATE || rq.func == FUNC_REGISTER || rq.func == FUNC_FIND)
               rq.obj_ref = pick_object_ref();
            if (rq.func == FUNC_RELEASE || rq.func == FUNC_LOOKUP) begin
               slot = pick_live_slot();
               p    = $urandom_range(0, 99);
               if (slot >= 0 && p < 70) begin
                  rq.idx = HIDX_W'(slot);
                  rq.gen = sb.slot_gen[slot];
               end else if (slot >= 0 && p < 80) begin
                  // live slot, one generation bit flipped
                  rq.idx = HIDX_W'(slot);
                  rq.gen = sb.slot_gen[slot] ^ (32'd1 << $urandom_range(0, GEN_W - 1));
               end else if (p < 90) begin
                  // random slot, one generation behind its current one
                  rq.idx = HIDX_W'($urandom_range(0, SLOTS - 1));
                  rq.gen = sb.slot_gen[rq.idx] - 1'b1;
               end
            end
            send_request(rq);
            sent++;
         end
         if (phase % 2 == 1) drain_responses();
         phase++;
      end
      no_idle = 1'b0;

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("** generational_handle_slot_allocator_core: PASSED **");
      else
         $display("** generational_handle_slot_allocator_core: FAILED **");
      $finish;
   end

endmodule

>>> generational_handle_slot_allocator_core.f
+incdir+rtl
rtl/ghsa_pkg.sv
rtl/generational_handle_slot_allocator_core.sv
rtl/ghsa_checker.sv
tb/tb_generational_handle_slot_allocator_core.sv
